[hdl/sdpc_pkg.sv]
// ============================================================================
// sdpc_pkg: shared types and constants of the stereo dot product cost core
// Request codes, register indexes and field widths of the stream channels.
// ============================================================================
package sdpc_pkg;

    // Request kinds carried in s_tuser
    localparam logic [1:0] MODE_WR_LEFT  = 2'd0;
    localparam logic [1:0] MODE_WR_RIGHT = 2'd1;
    localparam logic [1:0] MODE_QUERY    = 2'd2;

    // Configuration register indexes (byte address / 4)
    localparam logic [1:0] REG_DISP_MIN  = 2'd0;
    localparam logic [1:0] REG_DISP_MAX  = 2'd1;
    localparam logic [1:0] REG_ROW_WIDTH = 2'd2;
    localparam logic [1:0] REG_CHANNELS  = 2'd3;

    localparam int PADDR_W   = 4;
    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 40;
    localparam int COST_W    = 38;
    localparam int FEAT_W    = 16;
    localparam int PROD_W    = 32;
    // Holds up to 256 products of 2^30 with room for the negation.
    localparam int ACC_W     = 48;

endpackage

[hdl/sdpc_ram.sv]
// ============================================================================
// sdpc_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ============================================================================
module sdpc_ram #(
    parameter int DATA_W = 16,
    parameter int DEPTH  = 65536
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [DATA_W-1:0]        wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [DATA_W-1:0]        rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[hdl/stereo_dot_product_cost_core.sv]
// ============================================================================
// stereo_dot_product_cost_core: feature correlation cost for one image row
// Row stores for left and right features and a shared multiply-accumulate.
// ============================================================================
// Usage:
// The slave stream carries requests. s_tuser selects the kind: write a left
// feature, write a right feature, or query a cost. A write stores one Q1.15
// element at (column, channel) and returns nothing; s_tready stays high.
// A query reads channel_count pairs of features, one pair per cycle through
// one multiplier and accumulator, and returns one result on the master
// stream: the negated Q2.30 dot product, saturated to 38 bits, with
// cost_valid in m_tuser. An invalid query returns cost 0.
// A valid query passes the check, multiply-accumulate and saturation steps
// with channel_count capped at MAX_CHANNELS, an invalid one skips the
// multiply-accumulate; s_tready is low until the core is idle again. Store
// reads pass the RAM and multiplier registers. The result waits in an output
// register, so writes and the next query are taken while the receiver stalls;
// a finished query only holds in its last step until that register is free.
// Reset clears the sequencer and output valid and restores the register
// defaults. Feature stores are not cleared and must be written before use.
// The user must write registers on the APB port only while idle; not enforced.
// ============================================================================
module stereo_dot_product_cost_core #(
    parameter int MAX_WIDTH    = 1024,
    parameter int MAX_CHANNELS = 64
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // APB configuration port
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [sdpc_pkg::PADDR_W-1:0]   paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready,
    // Request stream
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // column[9:0], channel[15:10], feature_value[31:16], disparity_index[40:32]
    input  logic [sdpc_pkg::S_TDATA_W-1:0] s_tdata,
    // mode[1:0]
    input  logic [1:0]                     s_tuser,
    // Result stream
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // cost[37:0]
    output logic [sdpc_pkg::M_TDATA_W-1:0] m_tdata,
    // cost_valid[0]
    output logic [0:0]                     m_tuser
);

    localparam int DEPTH  = MAX_WIDTH * MAX_CHANNELS;
    localparam int AW     = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(MAX_CHANNELS + 1);
    localparam int WW     = $clog2(MAX_WIDTH + 1);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_CHECK = 4'b0010,
        ST_MAC   = 4'b0100,
        ST_SAT   = 4'b1000
    } state_t;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic signed [8:0] disp_min_reg;
    logic signed [8:0] disp_max_reg;
    logic [10:0]       row_width_reg;
    logic [6:0]        channels_reg;
    logic              cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            disp_min_reg  <= 9'sd0;
            disp_max_reg  <= 9'sd63;
            row_width_reg <= 11'd1024;
            channels_reg  <= 7'd64;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                sdpc_pkg::REG_DISP_MIN:  disp_min_reg  <= pwdata[8:0];
                sdpc_pkg::REG_DISP_MAX:  disp_max_reg  <= pwdata[8:0];
                sdpc_pkg::REG_ROW_WIDTH: row_width_reg <= pwdata[10:0];
                sdpc_pkg::REG_CHANNELS:  channels_reg  <= pwdata[6:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            sdpc_pkg::REG_DISP_MIN:  prdata = {23'd0, disp_min_reg};
            sdpc_pkg::REG_DISP_MAX:  prdata = {23'd0, disp_max_reg};
            sdpc_pkg::REG_ROW_WIDTH: prdata = {21'd0, row_width_reg};
            sdpc_pkg::REG_CHANNELS:  prdata = {25'd0, channels_reg};
        endcase
    end

    // ------------------------------------------------------------------
    // Request fields
    // ------------------------------------------------------------------
    logic [9:0]  in_column;
    logic [5:0]  in_channel;
    logic [15:0] in_feature;
    logic [8:0]  in_index;
    logic        in_accept;

    assign in_column  = s_tdata[9:0];
    assign in_channel = s_tdata[15:10];
    assign in_feature = s_tdata[31:16];
    assign in_index   = s_tdata[40:32];

    state_t state_reg, state_next;

    assign s_tready  = (state_reg == ST_IDLE);
    assign in_accept = s_tvalid & s_tready;

    // Feature writes go straight into the stores.
    logic          wr_in_store;
    logic          wr_left;
    logic          wr_right;
    logic [AW-1:0] wr_addr;

    assign wr_in_store = (32'(in_column) < MAX_WIDTH) && (32'(in_channel) < MAX_CHANNELS);
    assign wr_left  = in_accept && (s_tuser == sdpc_pkg::MODE_WR_LEFT) && wr_in_store;
    assign wr_right = in_accept && (s_tuser == sdpc_pkg::MODE_WR_RIGHT) && wr_in_store;
    assign wr_addr  = AW'(32'(in_column) * MAX_CHANNELS + 32'(in_channel));

    // ------------------------------------------------------------------
    // Query sequencer
    // ------------------------------------------------------------------
    logic [9:0]                  q_col_reg;
    logic [8:0]                  q_idx_reg;
    logic                        q_valid_reg;
    logic [AW-1:0]               l_base_reg;
    logic [AW-1:0]               r_base_reg;
    logic [CNT_W-1:0]            nch_reg;
    logic [CNT_W-1:0]            cnt_reg;
    logic                        rd_vld_reg;
    logic                        prod_vld_reg;
    logic signed [sdpc_pkg::PROD_W-1:0] prod_reg;
    logic signed [sdpc_pkg::ACC_W-1:0]  acc_reg;

    logic [sdpc_pkg::COST_W-1:0] out_cost_reg;
    logic                        out_valid_flag_reg;
    logic                        m_valid_reg;

    // Range checks of the query, evaluated in the check step
    logic signed [11:0] rcol;
    logic signed [9:0]  span;
    logic [WW-1:0]      w_eff;
    logic [CNT_W-1:0]   nch_eff;
    logic               q_valid_calc;

    assign rcol = $signed({2'b00, q_col_reg}) + $signed({{3{disp_min_reg[8]}}, disp_min_reg})
                + $signed({3'b000, q_idx_reg});
    assign span = $signed({disp_max_reg[8], disp_max_reg})
                - $signed({disp_min_reg[8], disp_min_reg});
    assign w_eff = (32'(row_width_reg) > MAX_WIDTH) ? WW'(MAX_WIDTH) : WW'(row_width_reg);
    assign nch_eff = (32'(channels_reg) > MAX_CHANNELS) ? CNT_W'(MAX_CHANNELS)
                                                        : CNT_W'(channels_reg);
    assign q_valid_calc = ($signed({1'b0, q_idx_reg}) <= span)
                       && (32'(q_col_reg) < 32'(w_eff))
                       && !rcol[11]
                       && ({20'd0, rcol[11:0]} < 32'(w_eff));

    logic          issue;
    logic          mac_done;
    logic          out_free;
    logic [AW-1:0] l_raddr;
    logic [AW-1:0] r_raddr;

    assign issue    = (state_reg == ST_MAC) && (cnt_reg < nch_reg);
    assign mac_done = !issue && !rd_vld_reg && !prod_vld_reg;
    assign out_free = !m_valid_reg || m_tready;
    assign l_raddr  = l_base_reg + AW'(cnt_reg);
    assign r_raddr  = r_base_reg + AW'(cnt_reg);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept && (s_tuser == sdpc_pkg::MODE_QUERY))
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                state_next = q_valid_calc ? ST_MAC : ST_SAT;
            end
            ST_MAC:
            begin
                if (mac_done)
                begin
                    state_next = ST_SAT;
                end
            end
            ST_SAT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            rd_vld_reg   <= 1'b0;
            prod_vld_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            rd_vld_reg   <= issue;
            prod_vld_reg <= rd_vld_reg;
            if ((state_reg == ST_SAT) && out_free)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Saturation of the negated sum to the cost width
    logic signed [sdpc_pkg::ACC_W-1:0] neg_sum;
    logic [sdpc_pkg::ACC_W-sdpc_pkg::COST_W:0] neg_top;
    logic [sdpc_pkg::COST_W-1:0]       sat_cost;

    assign neg_sum = -acc_reg;
    assign neg_top = neg_sum[sdpc_pkg::ACC_W-1:sdpc_pkg::COST_W-1];

    always_comb
    begin
        if ((&neg_top) || !(|neg_top))
        begin
            sat_cost = neg_sum[sdpc_pkg::COST_W-1:0];
        end
        else if (neg_sum[sdpc_pkg::ACC_W-1])
        begin
            sat_cost = {1'b1, {(sdpc_pkg::COST_W-1){1'b0}}};
        end
        else
        begin
            sat_cost = {1'b0, {(sdpc_pkg::COST_W-1){1'b1}}};
        end
    end

    logic [sdpc_pkg::FEAT_W-1:0] l_rdata;
    logic [sdpc_pkg::FEAT_W-1:0] r_rdata;

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            q_col_reg <= in_column;
            q_idx_reg <= in_index;
        end
        if (state_reg == ST_CHECK)
        begin
            q_valid_reg <= q_valid_calc;
            l_base_reg  <= AW'(32'(q_col_reg) * MAX_CHANNELS);
            r_base_reg  <= AW'(32'(rcol[11:0]) * MAX_CHANNELS);
            nch_reg     <= nch_eff;
            cnt_reg     <= '0;
            acc_reg     <= '0;
        end
        else
        begin
            if (issue)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
            if (prod_vld_reg)
            begin
                acc_reg <= acc_reg + sdpc_pkg::ACC_W'(prod_reg);
            end
        end
        prod_reg <= $signed(l_rdata) * $signed(r_rdata);
        if ((state_reg == ST_SAT) && out_free)
        begin
            out_cost_reg       <= q_valid_reg ? sat_cost : '0;
            out_valid_flag_reg <= q_valid_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(sdpc_pkg::M_TDATA_W-sdpc_pkg::COST_W){1'b0}}, out_cost_reg};
    assign m_tuser  = out_valid_flag_reg;

    // ------------------------------------------------------------------
    // Feature row stores
    // ------------------------------------------------------------------
    sdpc_ram #(
        .DATA_W (sdpc_pkg::FEAT_W),
        .DEPTH  (DEPTH)
    ) u_left_ram (
        .clk   (clk),
        .we    (wr_left),
        .waddr (wr_addr),
        .wdata (in_feature),
        .raddr (l_raddr),
        .rdata (l_rdata)
    );

    sdpc_ram #(
        .DATA_W (sdpc_pkg::FEAT_W),
        .DEPTH  (DEPTH)
    ) u_right_ram (
        .clk   (clk),
        .we    (wr_right),
        .waddr (wr_addr),
        .wdata (in_feature),
        .raddr (r_raddr),
        .rdata (r_rdata)
    );

endmodule

[hdl/sdpc_checker.sv]
// ============================================================================
// sdpc_checker: port-level checks of the stereo dot product cost core
// Watches the stream ports over time; bound to the top level below.
// ============================================================================
module sdpc_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic [1:0]                     s_tuser,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [sdpc_pkg::M_TDATA_W-1:0] m_tdata,
    input logic [0:0]                     m_tuser
);

    // A stalled result stays offered.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // An invalid cost is reported as zero.
    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |-> m_tdata == '0)
        else $error("invalid cost is not zero");

    // A query occupies the core for at least the following cycle.
    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (s_tuser == sdpc_pkg::MODE_QUERY) |=> !s_tready)
        else $error("core ready right after a query");

    // Feature writes never stall the request side.
    a_write_ready: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (s_tuser == sdpc_pkg::MODE_WR_LEFT
                                 || s_tuser == sdpc_pkg::MODE_WR_RIGHT) |=> s_tready)
        else $error("core busy after a feature write");

    // Nothing is offered once reset has been seen at a clock edge.
    a_reset_idle: assert property (@(posedge clk)
        !rst_n |=> !m_tvalid)
        else $error("result offered after reset");

endmodule

bind stereo_dot_product_cost_core sdpc_checker u_sdpc_checker (.*);

[tb/sv/sdpc_cost_checker.sv]
`timescale 1ns / 1ps
// ============================================================================
// sdpc_cost_checker: cost predictor and result scoreboard
// Watches the APB port and both streams. It keeps its own copy of the
// registers and of the two feature rows, works out the cost of each accepted
// query, and compares every accepted result with the oldest open query.
// ============================================================================
module sdpc_cost_checker #(
    parameter int MAX_WIDTH    = 1024,
    parameter int MAX_CHANNELS = 64
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [sdpc_pkg::PADDR_W-1:0]   paddr,
    input  logic [31:0]                    pwdata,
    input  logic                           pready,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    // column[9:0], channel[15:10], feature_value[31:16], disparity_index[40:32]
    input  logic [sdpc_pkg::S_TDATA_W-1:0] s_tdata,
    // mode[1:0]
    input  logic [1:0]                     s_tuser,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    // cost[37:0]
    input  logic [sdpc_pkg::M_TDATA_W-1:0] m_tdata,
    // cost_valid[0]
    input  logic [0:0]                     m_tuser,
    output int                             mismatches,
    output int                             costs_pending
);
    import sdpc_pkg::*;

    localparam int     ROW_DEPTH = MAX_WIDTH * MAX_CHANNELS;
    localparam longint COST_MAX  = (longint'(1) << (COST_W - 1)) - 1;

    typedef struct packed {
        logic [COST_W-1:0] cost;
        logic              valid;
    } cost_result_t;

    logic signed [FEAT_W-1:0] left_feat [0:ROW_DEPTH-1];
    logic signed [FEAT_W-1:0] right_feat [0:ROW_DEPTH-1];

    logic signed [8:0] disp_min_q;
    logic signed [8:0] disp_max_q;
    logic [10:0]       width_q;
    logic [6:0]        chan_q;

    cost_result_t queued_costs[$];
    cost_result_t oldest;
    int           error_total = 0;
    int           wr_col;
    int           wr_chan;

    function automatic cost_result_t correlation_cost(input logic [9:0] col,
                                                      input logic [8:0] idx);
        int           dmin;
        int           dmax;
        int           weff;
        int           neff;
        int           rcol;
        int           la;
        int           ra;
        longint       sum;
        longint       cost;
        cost_result_t res;
        dmin = int'(disp_min_q);
        dmax = int'(disp_max_q);
        weff = (width_q > MAX_WIDTH) ? MAX_WIDTH : int'(width_q);
        neff = (chan_q > MAX_CHANNELS) ? MAX_CHANNELS : int'(chan_q);
        rcol = int'(col) + dmin + int'(idx);
        res.cost = '0;
        res.valid = (int'(idx) <= dmax - dmin) && (int'(col) < weff) &&
                    (rcol >= 0) && (rcol < weff);
        if (res.valid)
        begin
            sum = 0;
            la = int'(col) * MAX_CHANNELS;
            ra = rcol * MAX_CHANNELS;
            for (int c = 0; c < neff; c++)
                sum += longint'(left_feat[la + c]) * longint'(right_feat[ra + c]);
            cost = -sum;
            if (cost > COST_MAX)
                cost = COST_MAX;
            if (cost < -COST_MAX - 1)
                cost = -COST_MAX - 1;
            res.cost = cost[COST_W-1:0];
        end
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch at %0t: %s, got %h, expected %h", $realtime, what, got, want);
        error_total++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            disp_min_q = 9'sd0;
            disp_max_q = 9'sd63;
            width_q = 11'd1024;
            chan_q = 7'd64;
            queued_costs.delete();
            costs_pending <= 0;
            mismatches <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (queued_costs.size() == 0)
                    report_mismatch("result with no query open", 64'(m_tdata), 64'd0);
                else
                begin
                    oldest = queued_costs.pop_front();
                    if (m_tdata[COST_W-1:0] !== oldest.cost)
                        report_mismatch("cost", 64'(m_tdata[COST_W-1:0]), 64'(oldest.cost));
                    if (m_tuser[0] !== oldest.valid)
                        report_mismatch("cost_valid", 64'(m_tuser[0]), 64'(oldest.valid));
                end
            end

            if (psel && penable && pwrite && pready)
            begin
                case (paddr[3:2])
                    REG_DISP_MIN:  disp_min_q = pwdata[8:0];
                    REG_DISP_MAX:  disp_max_q = pwdata[8:0];
                    REG_ROW_WIDTH: width_q = pwdata[10:0];
                    REG_CHANNELS:  chan_q = pwdata[6:0];
                    default: ;
                endcase
            end

            if (s_tvalid && s_tready)
            begin
                wr_col = int'(s_tdata[9:0]);
                wr_chan = int'(s_tdata[15:10]);
                case (s_tuser)
                    MODE_WR_LEFT:
                        if (wr_col < MAX_WIDTH && wr_chan < MAX_CHANNELS)
                            left_feat[wr_col * MAX_CHANNELS + wr_chan] = s_tdata[31:16];
                    MODE_WR_RIGHT:
                        if (wr_col < MAX_WIDTH && wr_chan < MAX_CHANNELS)
                            right_feat[wr_col * MAX_CHANNELS + wr_chan] = s_tdata[31:16];
                    MODE_QUERY:
                        queued_costs.push_back(correlation_cost(s_tdata[9:0], s_tdata[40:32]));
                    default: ;
                endcase
            end

            costs_pending <= queued_costs.size();
            mismatches <= error_total;
        end
    end

endmodule

[tb/sv/stereo_dot_product_cost_core_test.sv]
`timescale 1ns / 1ps
// ============================================================================
// stereo_dot_product_cost_core_test: stimulus and verdict for the cost core
// Loads feature rows and sends cost queries under a series of register
// settings, with random stalls on both streams; the checker beside the core
// predicts and compares every result.
// ============================================================================
module stereo_dot_product_cost_core_test;
    import sdpc_pkg::*;

    localparam int         ROW_COLS       = 1024;
    localparam int         ROW_CHANS      = 64;
    localparam int         PHASE_REQUESTS = 140;
    localparam int         SETTLE_CYCLES  = 100;
    localparam int         CYCLE_LIMIT    = 1000000;
    localparam int         PHASES         = 9;
    localparam logic [1:0] MODE_UNUSED    = 2'd3;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [PADDR_W-1:0]   paddr = '0;
    logic [31:0]          pwdata = '0;
    logic [31:0]          prdata;
    logic                 pready;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic [1:0]           s_tuser = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [0:0]           m_tuser;

    int mismatches;
    int costs_pending;
    int tx_idle_pct = 31;
    int rx_idle_pct = 47;
    int cycle_count = 0;
    // Requests taken by the core so far, preload writes included.
    int sent_count = 0;

    // Store entries written so far; a valid query never reads any other.
    bit left_loaded [0:ROW_COLS*ROW_CHANS-1];
    bit right_loaded [0:ROW_COLS*ROW_CHANS-1];

    int cfg_dmin = 0;
    int cfg_dmax = 63;
    int cfg_width = 1024;
    int cfg_chans = 64;
    int col_pool [0:7];

    // disparity_min, disparity_max, row_width, channel_count per phase
    int phase_cfg [0:PHASES-1][0:3] = '{
        '{-4, 4, 16, 8},
        '{-255, 255, 1024, 64},
        '{10, 2, 20, 4},
        '{0, 0, 1, 1},
        '{255, 255, 1024, 1},
        '{-255, -200, 300, 0},
        '{0, 63, 0, 5},
        '{-8, 20, 2047, 127},
        '{-16, 16, 64, 16}
    };

    stereo_dot_product_cost_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    sdpc_cost_checker cost_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .pready        (pready),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .mismatches    (mismatches),
        .costs_pending (costs_pending)
    );

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Offers one request and returns at the edge where it is taken.
    task automatic send_req(input logic [1:0] kind, input int col, input int chan,
                            input int value, input int idx);
        logic [S_TDATA_W-1:0] data;
        data = '0;
        data[9:0] = col[9:0];
        data[15:10] = chan[5:0];
        data[31:16] = value[15:0];
        data[40:32] = idx[8:0];
        if ($urandom_range(99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < tx_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tuser <= kind;
        s_tdata <= data;
        do
            @(posedge clk);
        while (!s_tready);
        sent_count++;
    endtask

    task automatic write_feature(input logic [1:0] side, input int col, input int chan,
                                 input int value);
        send_req(side, col, chan, value, $urandom_range(511));
        if (side == MODE_WR_LEFT)
            left_loaded[col * ROW_CHANS + chan] = 1'b1;
        else
            right_loaded[col * ROW_CHANS + chan] = 1'b1;
    endtask

    // Loads whatever a valid query would read but was never written, then queries.
    task automatic query_cost(input int col, input int idx);
        int weff;
        int neff;
        int rcol;
        weff = (cfg_width > ROW_COLS) ? ROW_COLS : cfg_width;
        neff = (cfg_chans > ROW_CHANS) ? ROW_CHANS : cfg_chans;
        rcol = col + cfg_dmin + idx;
        if (idx <= cfg_dmax - cfg_dmin && col < weff && rcol >= 0 && rcol < weff)
        begin
            for (int c = 0; c < neff; c++)
            begin
                if (!left_loaded[col * ROW_CHANS + c])
                    write_feature(MODE_WR_LEFT, col, c, $urandom_range(65535));
                if (!right_loaded[rcol * ROW_CHANS + c])
                    write_feature(MODE_WR_RIGHT, rcol, c, $urandom_range(65535));
            end
        end
        send_req(MODE_QUERY, col, $urandom_range(63), $urandom_range(65535), idx);
    endtask

    // Waits until every query has answered and the core has gone quiet.
    task automatic settle();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (costs_pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic apb_write(input logic [1:0] index, input int value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {index, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
    endtask

    task automatic set_config(input int dmin, input int dmax, input int width,
                              input int chans);
        int weff;
        settle();
        apb_write(REG_DISP_MIN, dmin & 32'h1FF);
        apb_write(REG_DISP_MAX, dmax & 32'h1FF);
        apb_write(REG_ROW_WIDTH, width);
        apb_write(REG_CHANNELS, chans);
        psel <= 1'b0;
        penable <= 1'b0;
        cfg_dmin = dmin;
        cfg_dmax = dmax;
        cfg_width = width;
        cfg_chans = chans;
        weff = (width > ROW_COLS) ? ROW_COLS : width;
        col_pool[0] = 0;
        col_pool[1] = (weff > 0) ? weff - 1 : ROW_COLS - 1;
        for (int k = 2; k < 8; k++)
            col_pool[k] = $urandom_range((weff > 0) ? weff - 1 : ROW_COLS - 1);
    endtask

    // Mostly writes and queries on a few hot columns so that queries land on
    // loaded data, with unused requests and scattered columns mixed in.
    task automatic run_random_phase();
        int start_count;
        int pick;
        int col;
        int rcol;
        int idx;
        int chan;
        int value;
        int neff;
        start_count = sent_count;
        neff = (cfg_chans > ROW_CHANS) ? ROW_CHANS : cfg_chans;
        while (sent_count - start_count < PHASE_REQUESTS)
        begin
            pick = $urandom_range(99);
            if (pick < 3)
                send_req(MODE_UNUSED, $urandom_range(1023), $urandom_range(63),
                         $urandom_range(65535), $urandom_range(511));
            else if (pick < 48)
            begin
                col = ($urandom_range(99) < 80) ? col_pool[$urandom_range(7)]
                                                : $urandom_range(1023);
                chan = (neff > 0 && $urandom_range(99) < 85) ? $urandom_range(neff - 1)
                                                             : $urandom_range(63);
                case ($urandom_range(9))
                    0: value = -32768;
                    1: value = 32767;
                    default: value = $urandom_range(65535);
                endcase
                write_feature(($urandom_range(1) == 0) ? MODE_WR_LEFT : MODE_WR_RIGHT,
                              col, chan, value);
            end
            else if ($urandom_range(99) < 85)
            begin
                col = col_pool[$urandom_range(7)];
                rcol = col_pool[$urandom_range(7)];
                idx = rcol - col - cfg_dmin;
                if (idx < 0 || idx > 511)
                    idx = (cfg_dmax >= cfg_dmin && $urandom_range(1) == 1)
                          ? $urandom_range(cfg_dmax - cfg_dmin) : $urandom_range(511);
                query_cost(col, idx);
            end
            else
                query_cost($urandom_range(1023), $urandom_range(511));
        end
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Register defaults: index past disparity_max, right column past the
        // row end, the top index, and an unused request.
        query_cost(0, 64);
        query_cost(1023, 1);
        query_cost(5, 511);
        send_req(MODE_UNUSED, 1023, 63, 65535, 511);

        // Extreme features on two channels.
        set_config(0, 63, 1024, 2);
        write_feature(MODE_WR_LEFT, 0, 0, -32768);
        write_feature(MODE_WR_LEFT, 0, 1, -32768);
        write_feature(MODE_WR_RIGHT, 0, 0, -32768);
        write_feature(MODE_WR_RIGHT, 0, 1, -32768);
        query_cost(0, 0);
        write_feature(MODE_WR_RIGHT, 1, 0, 32767);
        write_feature(MODE_WR_RIGHT, 1, 1, 32767);
        query_cost(0, 1);
        write_feature(MODE_WR_LEFT, 1023, 63, 32767);
        write_feature(MODE_WR_RIGHT, 1023, 0, 32767);
        write_feature(MODE_WR_RIGHT, 1023, 1, -1);
        query_cost(1023, 0);

        // Negative disparity: right column below zero twice, then a valid one.
        set_config(-3, 3, 8, 2);
        query_cost(0, 2);
        query_cost(2, 0);
        query_cost(3, 0);

        for (int p = 0; p < PHASES; p++)
        begin
            set_config(phase_cfg[p][0], phase_cfg[p][1], phase_cfg[p][2], phase_cfg[p][3]);
            if (p < 3)
            begin
                tx_idle_pct = 31;
                rx_idle_pct = 47;
            end
            else if (p < 6)
            begin
                tx_idle_pct = 47;
                rx_idle_pct = 31;
            end
            else
            begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            run_random_phase();
        end

        settle();
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
